### rtl/core/jet_pkg.sv
package jet_pkg;

    // Fixed word formats of the datapath
    localparam int WORD_W  = 32;            // z, c: signed fixed point
    localparam int PROD_W  = 2 * WORD_W;    // full product of two words
    localparam int ACC_W   = PROD_W + 1;    // difference of two products
    localparam int PIX_W   = 10;
    localparam int STEP_W  = 27;
    localparam int CNT_W   = 9;
    localparam int COLOR_W = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_C_REAL = 2'd0;
    localparam logic [1:0] CFG_C_IMAG = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;

    // Register reset values
    localparam logic [WORD_W-1:0] RST_C_REAL = 32'hF800_0000; // -1.0
    localparam logic [WORD_W-1:0] RST_C_IMAG = 32'd21474836;  // about 0.16
    localparam logic [STEP_W-1:0] RST_STEP   = 27'd524800;

    localparam logic [COLOR_W-1:0] COLOR_BASE = 16'hFF00;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Clamp a wide signed value to the signed word range
    function automatic t_word sat_word(input t_acc v);
        t_word r;
        if (v > t_acc'(signed'(32'sh7FFF_FFFF))) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < t_acc'(signed'(32'sh8000_0000))) begin
            r = 32'sh8000_0000;
        end else begin
            r = t_word'(v);
        end
        return r;
    endfunction

endpackage

### rtl/core/julia_escape_time_pixel_unit.sv
// A request runs S_SX, S_SY, S_SZ and then R rounds, R = rounds run (1..MAX_ITER).
// No new request is taken until the last result has moved to the output register. Each
//   round uses the single 32x32 multiplier for zr*zr, zi*zi and zr*zi, then updates z.
// Reset (synchronous, active low): sequencer idle, output empty, constants back
//   to c = -1.0 + 0.16i and the default pixel step.
module julia_escape_time_pixel_unit #(
    parameter int IMAGE_SIZE = 1024,
    parameter int MAX_ITER   = 256,
    parameter int FRAC_BITS  = 27
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,

    // pixel request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,

    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_out_x,
    output logic [9:0]  o_out_y,
    output logic [8:0]  o_round_count,
    output logic        o_escaped,
    output logic [15:0] o_pixel_color
);

    localparam int CENTRE = (IMAGE_SIZE - 1) / 2;
    localparam int N_W    = $clog2(MAX_ITER + 1);

    // escape bound +-2.0 in the working format
    localparam jet_pkg::t_acc LIM = jet_pkg::t_acc'(2) <<< FRAC_BITS;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request
    localparam logic [2:0] S_SX   = 3'd1;  // dx * step
    localparam logic [2:0] S_SY   = 3'd2;  // dy * step, store zr0
    localparam logic [2:0] S_SZ   = 3'd3;  // store zi0
    localparam logic [2:0] S_MRR  = 3'd4;  // zr * zr
    localparam logic [2:0] S_MII  = 3'd5;  // zi * zi
    localparam logic [2:0] S_MRI  = 3'd6;  // zr * zi, form zr^2 - zi^2
    localparam logic [2:0] S_UPD  = 3'd7;  // add c, test bound, step or finish

    // configuration
    logic [31:0] r_c_real;
    logic [31:0] r_c_imag;
    logic [26:0] r_step;

    // sequencer and datapath
    logic [2:0]        r_state, n_state;
    logic              r_done;       // result waiting to move to output register
    logic              r_esc;
    logic [N_W-1:0]    r_n;
    logic [9:0]        r_px, r_py;
    jet_pkg::t_word    r_zr, r_zi;
    jet_pkg::t_prod    r_prod;
    jet_pkg::t_acc     r_acc;

    // output register
    logic              r_ov;
    logic [9:0]        r_ox, r_oy;
    logic [8:0]        r_ocnt;
    logic              r_oesc;
    logic [15:0]       r_ocol;

    jet_pkg::t_word    mul_a, mul_b;
    jet_pkg::t_prod    w_prod;
    jet_pkg::t_word    w_dx, w_dy, w_step;
    jet_pkg::t_acc     w_re, w_im;
    logic              w_out;        // update leaves the bound
    logic              w_last;       // final permitted round
    logic              w_load;       // output register takes the result

    // pixel offsets from the image centre
    assign w_dx   = jet_pkg::t_word'({22'd0, r_px}) - jet_pkg::t_word'(CENTRE);
    assign w_dy   = jet_pkg::t_word'({22'd0, r_py}) - jet_pkg::t_word'(CENTRE);
    assign w_step = jet_pkg::t_word'({5'd0, r_step});

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_SX: begin
                mul_a = w_dx;
                mul_b = w_step;
            end
            S_SY: begin
                mul_a = w_dy;
                mul_b = w_step;
            end
            S_MRR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            S_MII: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            S_MRI: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
        endcase
    end

    assign w_prod = jet_pkg::t_prod'(mul_a) * jet_pkg::t_prod'(mul_b);

    // new z before saturation; arithmetic shifts give floor rounding
    assign w_re = (r_acc >>> FRAC_BITS)
                + jet_pkg::t_acc'(signed'(r_c_real));
    assign w_im = (jet_pkg::t_acc'(r_prod) >>> (FRAC_BITS - 1))
                + jet_pkg::t_acc'(signed'(r_c_imag));

    assign w_out  = (w_re < -LIM) || (w_re > LIM) || (w_im < -LIM) || (w_im > LIM);
    assign w_last = (r_n == N_W'(MAX_ITER - 1));
    assign w_load = r_done && (!r_ov || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_done) begin
                    n_state = S_SX;
                end
            end
            S_SX:  n_state = S_SY;
            S_SY:  n_state = S_SZ;
            S_SZ:  n_state = S_MRR;
            S_MRR: n_state = S_MII;
            S_MII: n_state = S_MRI;
            S_MRI: n_state = S_UPD;
            S_UPD: begin
                if (w_out || w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MRR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold off new requests while a pixel is in flight or its result is parked
    assign o_stall = (r_state != S_IDLE) || r_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real <= jet_pkg::RST_C_REAL;
            r_c_imag <= jet_pkg::RST_C_IMAG;
            r_step   <= jet_pkg::RST_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jet_pkg::CFG_C_REAL: r_c_real <= i_cfg_data;
                jet_pkg::CFG_C_IMAG: r_c_imag <= i_cfg_data;
                jet_pkg::CFG_STEP:   r_step   <= i_cfg_data[26:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD && (w_out || w_last)) begin
                r_done <= 1'b1;
            end else if (w_load) begin
                r_done <= 1'b0;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_done) begin
                    r_px <= i_pixel_x;
                    r_py <= i_pixel_y;
                end
            end
            S_SY: r_zr <= jet_pkg::sat_word(jet_pkg::t_acc'(r_prod));
            S_SZ: begin
                r_zi  <= jet_pkg::sat_word(jet_pkg::t_acc'(r_prod));
                r_n   <= '0;
                r_esc <= 1'b0;
            end
            S_MII: r_acc <= jet_pkg::t_acc'(r_prod);
            S_MRI: r_acc <= r_acc - jet_pkg::t_acc'(r_prod);
            S_UPD: begin
                if (w_out) begin
                    r_esc <= 1'b1;
                end else begin
                    r_zr <= jet_pkg::sat_word(w_re);
                    r_zi <= jet_pkg::sat_word(w_im);
                    r_n  <= r_n + N_W'(1);
                end
            end
            default: ;
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ox   <= r_px;
            r_oy   <= r_py;
            r_ocnt <= 9'(r_n);
            r_oesc <= r_esc;
            r_ocol <= r_esc ? 16'(jet_pkg::COLOR_BASE + 16'(r_n)) : 16'd0;
        end
    end

    assign o_valid       = r_ov;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_round_count = r_ocnt;
    assign o_escaped     = r_oesc;
    assign o_pixel_color = r_ocol;

endmodule
